/* src/wmlru_pkg.sv */
// Shared types and constants for the window map LRU cache core.
`timescale 1ns / 1ps

package wmlru_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int ID_W          = 16;
	localparam int REL_W         = 3;
	localparam int REF_W         = 8;
	localparam int STAMP_W       = 32;
	localparam int CNT_W         = 32;
	localparam int STATUS_W      = 3;

	typedef enum logic [0:0] {
		OP_MAP     = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_NOFREE   = 3'd2,
		ST_RELEASED = 3'd3,
		ST_RELERR   = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	// One queued request, decoded by the front.
	typedef struct packed {
		op_t               op;
		logic [ID_W-1:0]   blk;
		logic [ID_W-1:0]   off;
		logic [REL_W-1:0]  slot;
		logic              discard;
		logic              rel_bad;
	} req_t;

	// Queue head as seen by the back.
	typedef struct packed {
		logic valid;
		req_t req;
	} head_t;

endpackage

/* src/wmlru_front.sv */
// Front end: accepts commands, flags out-of-range releases, queues requests.
`timescale 1ns / 1ps

module wmlru_front #(
	parameter int NUM_SLOTS = wmlru_pkg::NUM_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [0:0]                     opcode,
	input  logic [wmlru_pkg::ID_W-1:0]     block_id,
	input  logic [wmlru_pkg::ID_W-1:0]     block_offset,
	input  logic [wmlru_pkg::REL_W-1:0]    slot,
	input  logic                           discard,
	output wmlru_pkg::head_t               head,
	input  logic                           pop
);

	wmlru_pkg::req_t q_mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            do_pop;
	wmlru_pkg::req_t in_req;

	assign busy   = (count_q == 2'd2);
	assign push   = start && !busy;
	assign do_pop = pop && (count_q != 2'd0);

	always_comb begin
		in_req.op      = wmlru_pkg::op_t'(opcode);
		in_req.blk     = block_id;
		in_req.off     = block_offset;
		in_req.slot    = slot;
		in_req.discard = discard;
		in_req.rel_bad = (32'(slot) >= 32'(NUM_SLOTS));
	end

	assign head.valid = (count_q != 2'd0);
	assign head.req   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

/* src/wmlru_back.sv */
// Back end: slot table, tag lookup with oldest-free search, update and result.
`timescale 1ns / 1ps

module wmlru_back #(
	parameter int NUM_SLOTS = wmlru_pkg::NUM_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wmlru_pkg::head_t                head,
	output logic                            pop,
	output logic                            done,
	output logic [wmlru_pkg::STATUS_W-1:0]  status,
	output logic [wmlru_pkg::REL_W-1:0]     slot_used,
	output logic                            evicted,
	output logic [wmlru_pkg::ID_W-1:0]      evicted_block,
	output logic [wmlru_pkg::ID_W-1:0]      evicted_offset,
	output logic [wmlru_pkg::CNT_W-1:0]     hit_total,
	output logic [wmlru_pkg::CNT_W-1:0]     miss_total
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LEAVES = 1 << SLOT_W;
	localparam logic [wmlru_pkg::REF_W-1:0] REF_ONE = wmlru_pkg::REF_W'(1);

	typedef enum logic [1:0] {
		S_LOOK = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic                          slot_valid_q  [NUM_SLOTS];
	logic [wmlru_pkg::ID_W-1:0]    slot_block_q  [NUM_SLOTS];
	logic [wmlru_pkg::ID_W-1:0]    slot_offset_q [NUM_SLOTS];
	logic [wmlru_pkg::REF_W-1:0]   slot_ref_q    [NUM_SLOTS];
	logic [wmlru_pkg::STAMP_W-1:0] slot_stamp_q  [NUM_SLOTS];
	logic [wmlru_pkg::STAMP_W-1:0] stamp_ctr_q;
	logic [wmlru_pkg::CNT_W-1:0]   hit_cnt_q;
	logic [wmlru_pkg::CNT_W-1:0]   miss_cnt_q;

	// lookup results
	logic                          hit_c;
	logic [SLOT_W-1:0]             match_c;
	logic                          node_v [2*LEAVES];
	logic [SLOT_W-1:0]             node_i [2*LEAVES];
	logic [wmlru_pkg::STAMP_W-1:0] node_s [2*LEAVES];

	wmlru_pkg::req_t               req_s1;
	logic                          hit_s1;
	logic [SLOT_W-1:0]             match_s1;
	logic                          free_s1;
	logic [SLOT_W-1:0]             lru_s1;

	// execute-side decode
	logic [SLOT_W-1:0]             rel_idx;
	logic [SLOT_W-1:0]             idx;
	logic                          rel_ok;
	logic [wmlru_pkg::STAMP_W-1:0] stamp_next;
	logic [wmlru_pkg::REF_W-1:0]   ref_dec;

	assign pop = (state_q == S_LOOK) && head.valid;

	// Tag compare, lowest matching slot wins.
	always_comb begin
		hit_c   = 1'b0;
		match_c = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && slot_block_q[i] == head.req.blk &&
			    slot_offset_q[i] == head.req.off) begin
				hit_c   = 1'b1;
				match_c = SLOT_W'(i);
			end
		end
	end

	// Oldest free slot: min tree, left side (lower index) wins ties.
	always_comb begin
		node_v[0] = 1'b0;
		node_i[0] = '0;
		node_s[0] = '0;
		for (int i = 0; i < LEAVES; i++) begin
			if (i < NUM_SLOTS) begin
				node_v[LEAVES+i] = (slot_ref_q[i] == '0);
				node_s[LEAVES+i] = slot_stamp_q[i];
			end else begin
				node_v[LEAVES+i] = 1'b0;
				node_s[LEAVES+i] = '0;
			end
			node_i[LEAVES+i] = SLOT_W'(i);
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (node_v[2*n] && (!node_v[2*n+1] || node_s[2*n] <= node_s[2*n+1])) begin
				node_v[n] = 1'b1;
				node_i[n] = node_i[2*n];
				node_s[n] = node_s[2*n];
			end else begin
				node_v[n] = node_v[2*n+1];
				node_i[n] = node_i[2*n+1];
				node_s[n] = node_s[2*n+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_s1   <= head.req;
			hit_s1   <= hit_c;
			match_s1 <= match_c;
			free_s1  <= node_v[1];
			lru_s1   <= node_i[1];
		end
	end

	assign rel_idx    = SLOT_W'(req_s1.slot);
	assign stamp_next = stamp_ctr_q + 1'b1;
	assign rel_ok     = !req_s1.rel_bad && slot_valid_q[rel_idx] && (slot_ref_q[rel_idx] != '0);
	assign ref_dec    = slot_ref_q[rel_idx] - 1'b1;

	always_comb begin
		if (req_s1.op == wmlru_pkg::OP_RELEASE) begin
			idx = rel_idx;
		end else if (hit_s1) begin
			idx = match_s1;
		end else begin
			idx = lru_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOOK;
			stamp_ctr_q <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			done        <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_valid_q[i]  <= 1'b0;
				slot_block_q[i]  <= '0;
				slot_offset_q[i] <= '0;
				slot_ref_q[i]    <= '0;
				slot_stamp_q[i]  <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_LOOK: begin
					if (pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_LOOK;
					done    <= 1'b1;
					if (req_s1.op == wmlru_pkg::OP_RELEASE) begin
						if (rel_ok) begin
							stamp_ctr_q         <= stamp_next;
							slot_ref_q[idx]     <= ref_dec;
							slot_stamp_q[idx]   <= (ref_dec == '0 && req_s1.discard) ?
								'0 : stamp_next;
						end
					end else if (hit_s1) begin
						if (slot_ref_q[idx] != '1) begin
							stamp_ctr_q       <= stamp_next;
							slot_ref_q[idx]   <= slot_ref_q[idx] + 1'b1;
							slot_stamp_q[idx] <= stamp_next;
							hit_cnt_q         <= hit_cnt_q + 1'b1;
						end
					end else if (free_s1) begin
						stamp_ctr_q        <= stamp_next;
						miss_cnt_q         <= miss_cnt_q + 1'b1;
						slot_valid_q[idx]  <= 1'b1;
						slot_block_q[idx]  <= req_s1.blk;
						slot_offset_q[idx] <= req_s1.off;
						slot_ref_q[idx]    <= REF_ONE;
						slot_stamp_q[idx]  <= stamp_next;
					end
				end
				default: begin
					state_q <= S_LOOK;
				end
			endcase
		end
	end

	// Result register; counters shown as they stand after the beat.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			evicted        <= 1'b0;
			evicted_block  <= '0;
			evicted_offset <= '0;
			slot_used      <= wmlru_pkg::REL_W'(idx);
			hit_total      <= hit_cnt_q;
			miss_total     <= miss_cnt_q;
			if (req_s1.op == wmlru_pkg::OP_RELEASE) begin
				slot_used <= req_s1.slot;
				status    <= rel_ok ? wmlru_pkg::ST_RELEASED : wmlru_pkg::ST_RELERR;
			end else if (hit_s1) begin
				if (slot_ref_q[idx] == '1) begin
					status <= wmlru_pkg::ST_OVERFLOW;
				end else begin
					status    <= wmlru_pkg::ST_HIT;
					hit_total <= hit_cnt_q + 1'b1;
				end
			end else if (free_s1) begin
				status         <= wmlru_pkg::ST_MISS;
				miss_total     <= miss_cnt_q + 1'b1;
				evicted        <= slot_valid_q[idx];
				evicted_block  <= slot_valid_q[idx] ? slot_block_q[idx] : '0;
				evicted_offset <= slot_valid_q[idx] ? slot_offset_q[idx] : '0;
			end else begin
				status    <= wmlru_pkg::ST_NOFREE;
				slot_used <= '0;
			end
		end
	end

endmodule

/* src/window_map_lru_cache_core.sv */
// Top level: fully associative mapping table with LRU replacement and pinning.
// A request is written into the queue, captured by the lookup register, then done is registered in the update state.
// The back end handles one request at a time (lookup, then update) and pops the next only after the update.
// A two-entry queue lets start be taken while the back end works; busy is high when full.
// done pulses for one cycle with the result; the receiver cannot stall.
// arst_n clears all slots, stamps, counters and the queue at once.
`timescale 1ns / 1ps

module window_map_lru_cache_core #(
	parameter int NUM_SLOTS = wmlru_pkg::NUM_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [0:0]                      opcode,
	input  logic [wmlru_pkg::ID_W-1:0]      block_id,
	input  logic [wmlru_pkg::ID_W-1:0]      block_offset,
	input  logic [wmlru_pkg::REL_W-1:0]     slot,
	input  logic                            discard,
	output logic                            done,
	output logic [wmlru_pkg::STATUS_W-1:0]  status,
	output logic [wmlru_pkg::REL_W-1:0]     slot_used,
	output logic                            evicted,
	output logic [wmlru_pkg::ID_W-1:0]      evicted_block,
	output logic [wmlru_pkg::ID_W-1:0]      evicted_offset,
	output logic [wmlru_pkg::CNT_W-1:0]     hit_total,
	output logic [wmlru_pkg::CNT_W-1:0]     miss_total
);

	wmlru_pkg::head_t head;
	logic             pop;

	wmlru_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.block_id     (block_id),
		.block_offset (block_offset),
		.slot         (slot),
		.discard      (discard),
		.head         (head),
		.pop          (pop)
	);

	wmlru_back #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.done           (done),
		.status         (status),
		.slot_used      (slot_used),
		.evicted        (evicted),
		.evicted_block  (evicted_block),
		.evicted_offset (evicted_offset),
		.hit_total      (hit_total),
		.miss_total     (miss_total)
	);

endmodule
